// ===== sv/tse_pkg.sv =====
package tse_pkg;

  // request kinds at the input
  localparam logic [1:0] KIND_MOVE    = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [3:0] SLOT_NONE = 4'd15;

  // event types
  localparam logic [1:0] EVT_SYN = 2'd0;
  localparam logic [1:0] EVT_KEY = 2'd1;
  localparam logic [1:0] EVT_ABS = 2'd3;

  // event codes
  localparam logic [8:0] CODE_SYNC = 9'd0;
  localparam logic [8:0] CODE_SLOT = 9'd47;
  localparam logic [8:0] CODE_X    = 9'd53;
  localparam logic [8:0] CODE_Y    = 9'd54;
  localparam logic [8:0] CODE_TID  = 9'd57;
  localparam logic [8:0] CODE_BTN  = 9'd330;

  localparam logic [31:0] TID_BASE = 32'h0000_00e2;
  localparam logic [31:0] TID_LIFT = 32'hffff_ffff;

  // decoded request class
  typedef enum logic [1:0] {
    OP_REJ,
    OP_MOVE,
    OP_PRESS,
    OP_REL
  } op_e;

  // one emitted event
  typedef enum logic [2:0] {
    EV_SLOT,
    EV_TID,
    EV_BTN,
    EV_X,
    EV_Y,
    EV_SYNC,
    EV_REJ
  } ev_e;

  // decision from the slot table for one request
  typedef struct packed {
    op_e        op;
    logic [3:0] slot;
    logic       btn;
  } dec_t;

  // position in the full press/release list, skipping the button step when absent
  function automatic logic [2:0] seq_pos(logic [2:0] step, logic btn);
    logic [2:0] pos;
    if (btn || step < 3'd2) begin
      pos = step;
    end else begin
      pos = 3'(step + 3'd1);
    end
    return pos;
  endfunction

  // event emitted at a given step of a request
  function automatic ev_e seq_ev(op_e op, logic [2:0] step, logic btn);
    ev_e        ev;
    logic [2:0] pos;
    pos = seq_pos(step, btn);
    ev  = EV_REJ;
    unique case (op)
      OP_MOVE: begin
        unique case (step)
          3'd0:    ev = EV_SLOT;
          3'd1:    ev = EV_X;
          3'd2:    ev = EV_Y;
          default: ev = EV_SYNC;
        endcase
      end
      OP_PRESS: begin
        unique case (pos)
          3'd0:    ev = EV_SLOT;
          3'd1:    ev = EV_TID;
          3'd2:    ev = EV_BTN;
          3'd3:    ev = EV_X;
          3'd4:    ev = EV_Y;
          default: ev = EV_SYNC;
        endcase
      end
      OP_REL: begin
        unique case (pos)
          3'd0:    ev = EV_SLOT;
          3'd1:    ev = EV_TID;
          3'd2:    ev = EV_BTN;
          default: ev = EV_SYNC;
        endcase
      end
      default: ev = EV_REJ;
    endcase
    return ev;
  endfunction

endpackage

// ===== sv/tse_slot_tbl.sv =====
module tse_slot_tbl #(
  parameter int NUM_SLOTS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    kind_i,
  input  logic [3:0]    slot_i,
  output tse_pkg::dec_t dec_o
);

  logic [NUM_SLOTS-1:0] busy_q, busy_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 free_found;
  logic [3:0]           free_idx;
  logic [3:0]           cnt_dec, cnt_inc;
  logic                 bad_slot;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = tse_pkg::SLOT_NONE;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = 4'(i);
      end
    end
  end

  assign cnt_dec  = (cnt_q != 4'd0) ? 4'(cnt_q - 4'd1) : 4'd0;
  assign cnt_inc  = (cnt_q != 4'd15) ? 4'(cnt_q + 4'd1) : 4'd15;
  assign bad_slot = (slot_i != tse_pkg::SLOT_NONE) && (slot_i >= 4'(NUM_SLOTS));

  // request decision and next slot state
  always_comb begin
    dec_o.op   = tse_pkg::OP_REJ;
    dec_o.slot = slot_i;
    dec_o.btn  = 1'b0;
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    priority if (bad_slot) begin
      dec_o.op = tse_pkg::OP_REJ;
    end else if (kind_i == tse_pkg::KIND_MOVE) begin
      if (slot_i != tse_pkg::SLOT_NONE) begin
        dec_o.op = tse_pkg::OP_MOVE;
      end
    end else if (kind_i == tse_pkg::KIND_RELEASE) begin
      if (slot_i != tse_pkg::SLOT_NONE) begin
        dec_o.op  = tse_pkg::OP_REL;
        dec_o.btn = (cnt_dec == 4'd0);
        cnt_d     = cnt_dec;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_i == 4'(i)) begin
            busy_d[i] = 1'b0;
          end
        end
      end
    end else if (kind_i == tse_pkg::KIND_PRESS) begin
      if (slot_i != tse_pkg::SLOT_NONE) begin
        dec_o.op  = tse_pkg::OP_PRESS;
        dec_o.btn = (cnt_q == 4'd1);
      end else if (free_found) begin
        dec_o.op   = tse_pkg::OP_PRESS;
        dec_o.slot = free_idx;
        dec_o.btn  = (cnt_inc == 4'd1);
        cnt_d      = cnt_inc;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (free_idx == 4'(i)) begin
            busy_d[i] = 1'b1;
          end
        end
      end
    end else begin
      dec_o.op = tse_pkg::OP_REJ;
    end
    if (dec_o.op == tse_pkg::OP_REJ) begin
      dec_o.slot = tse_pkg::SLOT_NONE;
    end
  end

  // slot state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      cnt_q  <= 4'd0;
    end else if (accept_i) begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/touch_slot_event_generator.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+--------------------------------------------
// request   | start in, busy out          | kind_i, slot_i, pos_x_i, pos_y_i
// event     | valid_o strobe, no stall    | event_type_o, event_code_o, event_value_o,
//           |                             | granted_slot_o, rejected_o, last_o
//
// the number of events a request produces is 1 when rejected, 4 for a move,
// 3 or 4 for a release, 5 or 6 for a press; the event sequencer emits one per cycle
// a taken request is registered into the sequencer and each event then into the result
// registers before it is on the ports; busy drops while the last event of a request is
// being built, so the next request can be taken before that event is on the ports
// reset clears all slots, the active count and the sequencer; results cannot be stalled
module touch_slot_event_generator #(
  parameter int NUM_SLOTS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         slot_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  output logic               valid_o,
  output logic [1:0]         event_type_o,
  output logic [8:0]         event_code_o,
  output logic signed [31:0] event_value_o,
  output logic [3:0]         granted_slot_o,
  output logic               rejected_o,
  output logic               last_o
);

  logic          accept;
  tse_pkg::dec_t dec;

  logic          run_q;
  logic [2:0]    step_q;
  tse_pkg::op_e  op_q;
  logic [3:0]    slot_q;
  logic          btn_q;
  logic [15:0]   px_q, py_q;

  tse_pkg::ev_e  ev;
  logic          ev_last;
  logic [1:0]    type_d;
  logic [8:0]    code_d;
  logic [31:0]   value_d;

  logic          valid_q, rej_q, last_q;
  logic [1:0]    type_q;
  logic [8:0]    code_q;
  logic [31:0]   value_q;
  logic [3:0]    gslot_q;

  assign busy   = run_q && !ev_last;
  assign accept = start && !busy;

  tse_slot_tbl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .kind_i  (kind_i),
    .slot_i  (slot_i),
    .dec_o   (dec)
  );

  // current event and its fields
  always_comb begin
    ev      = tse_pkg::seq_ev(op_q, step_q, btn_q);
    ev_last = (ev == tse_pkg::EV_SYNC) || (ev == tse_pkg::EV_REJ);
    type_d  = tse_pkg::EVT_ABS;
    code_d  = tse_pkg::CODE_SYNC;
    value_d = 32'd0;
    unique case (ev)
      tse_pkg::EV_SLOT: begin
        code_d  = tse_pkg::CODE_SLOT;
        value_d = {28'd0, slot_q};
      end
      tse_pkg::EV_TID: begin
        code_d  = tse_pkg::CODE_TID;
        value_d = (op_q == tse_pkg::OP_PRESS) ? 32'(tse_pkg::TID_BASE + {28'd0, slot_q})
                                              : tse_pkg::TID_LIFT;
      end
      tse_pkg::EV_BTN: begin
        type_d  = tse_pkg::EVT_KEY;
        code_d  = tse_pkg::CODE_BTN;
        value_d = {31'd0, (op_q == tse_pkg::OP_PRESS)};
      end
      tse_pkg::EV_X: begin
        code_d  = tse_pkg::CODE_X;
        value_d = {16'd0, px_q};
      end
      tse_pkg::EV_Y: begin
        code_d  = tse_pkg::CODE_Y;
        value_d = {16'd0, py_q};
      end
      default: begin
        type_d  = tse_pkg::EVT_SYN;
        code_d  = tse_pkg::CODE_SYNC;
        value_d = 32'd0;
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 3'd0;
    end else if (accept) begin
      run_q  <= 1'b1;
      step_q <= 3'd0;
    end else if (run_q) begin
      run_q  <= !ev_last;
      step_q <= 3'(step_q + 3'd1);
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= dec.op;
      slot_q <= dec.slot;
      btn_q  <= dec.btn;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= run_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (run_q) begin
      type_q  <= type_d;
      code_q  <= code_d;
      value_q <= value_d;
      gslot_q <= slot_q;
      rej_q   <= (ev == tse_pkg::EV_REJ);
      last_q  <= ev_last;
    end
  end

  assign valid_o        = valid_q;
  assign event_type_o   = type_q;
  assign event_code_o   = code_q;
  assign event_value_o  = signed'(value_q);
  assign granted_slot_o = gslot_q;
  assign rejected_o     = rej_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // a refused transaction is always a single result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rejected_o |-> last_o)
    else $error("rejected result not marked last");

  // the first result follows an accepted request through the sequencer and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 valid_o)
    else $error("no result after accepted request");

  // results of one request come without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("gap inside a result sequence");

  // no new request is taken while a non-final event is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !ev_last |-> busy)
    else $error("request taken mid sequence");
`endif

endmodule

// ===== bench/touch_slot_event_generator_tb.sv =====
module touch_slot_event_generator_tb;

  localparam int NUM_SLOTS    = 10;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_WAIT  = 12;

  // kind code that the block does not define
  localparam logic [1:0] KIND_BAD = 2'd3;

  // one request transaction, with a flag for rows whose answer is a plain refusal
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        exp_reject;
  } touch_req_t;

  // one event transaction
  typedef struct packed {
    logic [1:0]  etype;
    logic [8:0]  code;
    logic [31:0] value;
    logic [3:0]  gslot;
    logic        rej;
    logic        last;
  } touch_evt_t;

  localparam touch_evt_t REJECT_EVT = '{tse_pkg::EVT_SYN, tse_pkg::CODE_SYNC, 32'd0,
                                        tse_pkg::SLOT_NONE, 1'b1, 1'b1};

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  logic [1:0]         kind_i  = tse_pkg::KIND_MOVE;
  logic [3:0]         slot_i  = tse_pkg::SLOT_NONE;
  logic [15:0]        pos_x_i = 16'd0;
  logic [15:0]        pos_y_i = 16'd0;
  logic               valid_o;
  logic [1:0]         event_type_o;
  logic [8:0]         event_code_o;
  logic signed [31:0] event_value_o;
  logic [3:0]         granted_slot_o;
  logic               rejected_o;
  logic               last_o;

  // slot table mirror
  logic [NUM_SLOTS-1:0] slot_taken = '0;
  logic [3:0]           live_count = 4'd0;

  touch_evt_t encoded_q[$];
  touch_evt_t pending_events[$];
  touch_req_t directed_reqs[$];
  touch_evt_t got_evt;
  touch_evt_t want_evt;
  int         idle_pct  = 0;
  int         err_cnt   = 0;
  int         cycle_cnt = 0;

  touch_slot_event_generator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .valid_o       (valid_o),
    .event_type_o  (event_type_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .granted_slot_o(granted_slot_o),
    .rejected_o    (rejected_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic put_event(input logic [1:0] etype, input logic [8:0] code,
                           input logic [31:0] value, input logic [3:0] gslot);
    encoded_q.push_back('{etype, code, value, gslot, 1'b0, 1'b0});
  endtask

  // expected event list of one request, updating the slot table mirror
  task automatic encode_touch(input touch_req_t r);
    logic [3:0] s;
    logic       refuse;
    touch_evt_t tail;
    int         i;
    encoded_q = {};
    s = r.slot;
    refuse = (r.kind == KIND_BAD) || (s != tse_pkg::SLOT_NONE && s >= NUM_SLOTS) ||
             (s == tse_pkg::SLOT_NONE && r.kind != tse_pkg::KIND_PRESS);
    // press without a slot claims the lowest free one
    if (!refuse && r.kind == tse_pkg::KIND_PRESS && s == tse_pkg::SLOT_NONE) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (s == tse_pkg::SLOT_NONE && !slot_taken[i]) begin
          s = 4'(i);
          slot_taken[i] = 1'b1;
          if (live_count < 4'd15) live_count++;
        end
      end
      refuse = (s == tse_pkg::SLOT_NONE);
    end
    if (refuse) begin
      encoded_q.push_back(REJECT_EVT);
    end else begin
      put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_SLOT, {28'd0, s}, s);
      case (r.kind)
        tse_pkg::KIND_MOVE: begin
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_X, {16'd0, r.pos_x}, s);
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_Y, {16'd0, r.pos_y}, s);
        end
        tse_pkg::KIND_RELEASE: begin
          slot_taken[s] = 1'b0;
          if (live_count > 4'd0) live_count--;
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_TID, tse_pkg::TID_LIFT, s);
          if (live_count == 4'd0) begin
            put_event(tse_pkg::EVT_KEY, tse_pkg::CODE_BTN, 32'd0, s);
          end
        end
        default: begin
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_TID, tse_pkg::TID_BASE + {28'd0, s}, s);
          if (live_count == 4'd1) begin
            put_event(tse_pkg::EVT_KEY, tse_pkg::CODE_BTN, 32'd1, s);
          end
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_X, {16'd0, r.pos_x}, s);
          put_event(tse_pkg::EVT_ABS, tse_pkg::CODE_Y, {16'd0, r.pos_y}, s);
        end
      endcase
      put_event(tse_pkg::EVT_SYN, tse_pkg::CODE_SYNC, 32'd0, s);
      tail = encoded_q.pop_back();
      tail.last = 1'b1;
      encoded_q.push_back(tail);
    end
  endtask

  // random request, mostly well-formed against the current slot table
  function automatic touch_req_t build_random_req();
    touch_req_t r;
    logic [3:0] live[$];
    int         pick;
    int         i;
    r.kind       = tse_pkg::KIND_PRESS;
    r.slot       = tse_pkg::SLOT_NONE;
    r.pos_x      = 16'($urandom_range(0, 65535));
    r.pos_y      = 16'($urandom_range(0, 65535));
    r.exp_reject = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_taken[i]) live.push_back(4'(i));
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.kind = 2'($urandom_range(0, 3));
      r.slot = 4'($urandom_range(0, 15));
    end else if (pick < 20) begin
      r.slot = 4'($urandom_range(0, NUM_SLOTS - 1));
    end else if (live.size() == 0 || pick < 45) begin
      r.slot = tse_pkg::SLOT_NONE;
    end else if (pick < 72) begin
      r.kind = tse_pkg::KIND_MOVE;
      r.slot = live[$urandom_range(0, live.size() - 1)];
    end else begin
      r.kind = tse_pkg::KIND_RELEASE;
      r.slot = live[$urandom_range(0, live.size() - 1)];
    end
    return r;
  endfunction

  // drive one request transaction and queue what it should produce
  task automatic send_touch(input touch_req_t r);
    touch_evt_t e;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= r.kind;
    slot_i  <= r.slot;
    pos_x_i <= r.pos_x;
    pos_y_i <= r.pos_y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    encode_touch(r);
    if (r.exp_reject) begin
      pending_events.push_back(REJECT_EVT);
    end else begin
      foreach (encoded_q[j]) begin
        e = encoded_q[j];
        pending_events.push_back(e);
      end
    end
  endtask

  // hold off the sender until every queued event has come out
  task automatic drain_events();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // event checker
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      got_evt = '{event_type_o, event_code_o, event_value_o, granted_slot_o,
                  rejected_o, last_o};
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %0h", $time, got_evt);
        err_cnt++;
      end else begin
        want_evt = pending_events.pop_front();
        check_field("event_type", 32'(want_evt.etype), 32'(got_evt.etype));
        check_field("event_code", 32'(want_evt.code), 32'(got_evt.code));
        check_field("event_value", want_evt.value, got_evt.value);
        check_field("granted_slot", 32'(want_evt.gslot), 32'(got_evt.gslot));
        check_field("rejected", 32'(want_evt.rej), 32'(got_evt.rej));
        check_field("last", 32'(want_evt.last), 32'(got_evt.last));
      end
    end
  end

  initial begin
    int k;
    // refusals: no slot on move and release, bad kind, slot out of range
    directed_reqs.push_back('{tse_pkg::KIND_MOVE, tse_pkg::SLOT_NONE, 16'h0000, 16'h0000,
                              1'b1});
    directed_reqs.push_back('{tse_pkg::KIND_RELEASE, tse_pkg::SLOT_NONE, 16'hffff, 16'hffff,
                              1'b1});
    directed_reqs.push_back('{KIND_BAD, 4'd0, 16'h1234, 16'h4321, 1'b1});
    directed_reqs.push_back('{tse_pkg::KIND_MOVE, 4'd10, 16'hffff, 16'h0000, 1'b1});
    directed_reqs.push_back('{tse_pkg::KIND_PRESS, 4'd14, 16'h0000, 16'hffff, 1'b1});
    // release of an idle slot with the count already at zero
    directed_reqs.push_back('{tse_pkg::KIND_RELEASE, 4'd3, 16'h0000, 16'h0000, 1'b0});
    // first contact, then a move at the coordinate extremes
    directed_reqs.push_back('{tse_pkg::KIND_PRESS, tse_pkg::SLOT_NONE, 16'h0000, 16'h0000,
                              1'b0});
    directed_reqs.push_back('{tse_pkg::KIND_MOVE, 4'd0, 16'hffff, 16'hffff, 1'b0});
    directed_reqs.push_back('{tse_pkg::KIND_PRESS, tse_pkg::SLOT_NONE, 16'hffff, 16'h0000,
                              1'b0});
    // press naming a free slot leaves the table alone
    directed_reqs.push_back('{tse_pkg::KIND_PRESS, 4'd5, 16'h1234, 16'habcd, 1'b0});
    // fill the remaining slots
    for (k = 0; k < NUM_SLOTS - 2; k++) begin
      directed_reqs.push_back('{tse_pkg::KIND_PRESS, tse_pkg::SLOT_NONE,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 1'b0});
    end
    // no free slot left
    directed_reqs.push_back('{tse_pkg::KIND_PRESS, tse_pkg::SLOT_NONE, 16'h5555, 16'haaaa,
                              1'b1});
    // release twice, the second one of a slot that is no longer held
    directed_reqs.push_back('{tse_pkg::KIND_RELEASE, 4'd9, 16'h0000, 16'h0000, 1'b0});
    directed_reqs.push_back('{tse_pkg::KIND_RELEASE, 4'd9, 16'h0000, 16'h0000, 1'b0});
    directed_reqs.push_back('{KIND_BAD, tse_pkg::SLOT_NONE, 16'hffff, 16'hffff, 1'b1});
    directed_reqs.push_back('{tse_pkg::KIND_MOVE, 4'd9, 16'hffff, 16'h0000, 1'b0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 19;
    foreach (directed_reqs[j]) send_touch(directed_reqs[j]);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        drain_events();
        idle_pct = 75;
      end else if (k == 2 * RANDOM_ITEMS / 3) begin
        drain_events();
        idle_pct = 0;
      end
      send_touch(build_random_req());
    end

    drain_events();
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
